@@ rtl/bir_pkg.sv @@
// bir_pkg: shared types, constants and helpers of the bilinear image resampler
// no dependencies; imported by every rtl module of the block
`default_nettype none

package bir_pkg;

    // sizes
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int OUT_INDEX_BITS = 24;
    localparam int DIM_W          = 9;
    localparam int CELL_W         = DIM_W - 1;
    localparam int ADDR_W         = 16;
    localparam int SAMPLE_W       = 16;
    localparam int OUT_WIDTH_W    = 16;
    localparam int SCALE_W        = 24;
    localparam int FRAC_W         = 16;
    localparam int CFG_DATA_W     = 24;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = QPTR_W + 1;

    localparam logic [FRAC_W:0] FRAC_ONE   = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
    localparam logic [DIM_W-1:0] DIM_MAX_X = DIM_W'(MAX_SRC_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_Y = DIM_W'(MAX_SRC_HEIGHT);

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_OUT_WIDTH  = 2'd0,
        CFG_SCALE_STEP = 2'd1,
        CFG_SRC_WIDTH  = 2'd2,
        CFG_SRC_HEIGHT = 2'd3
    } cfg_idx_t;

    // item classes
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  op;
        logic [ADDR_W-1:0]     src_addr;
        logic [SAMPLE_W-1:0]   sample;
        logic [23:0]           pixel_index;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   out_value;
        logic [23:0]           out_index;
    } res_item_t;

    typedef struct packed {
        kind_t                     kind;
        logic [ADDR_W-1:0]         addr;
        logic [SAMPLE_W-1:0]       sample;
        logic [OUT_INDEX_BITS-1:0] pix;
    } q_item_t;

    typedef struct packed {
        logic [OUT_WIDTH_W-1:0] out_width;
        logic [SCALE_W-1:0]     scale_step;
        logic [DIM_W-1:0]       src_width;
        logic [DIM_W-1:0]       src_height;
    } cfg_t;

    // queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // clamp a source dimension to its legal range
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
        begin
            r = DIM_MIN;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bir_front.sv @@
// bir_front: command intake, item classification and configuration registers
// depends on bir_pkg
`default_nettype none

module bir_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire bir_pkg::in_item_t           item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [bir_pkg::CFG_DATA_W-1:0] cfg_data,
    output bir_pkg::cfg_t                    cfg,
    input  wire bir_pkg::q_stat_t            q_stat,
    output logic                             push,
    output bir_pkg::q_item_t                 push_item
);
    import bir_pkg::*;

    logic    front_valid_reg, front_valid_next;
    q_item_t front_item_reg;
    cfg_t    cfg_reg, cfg_next;
    logic    accept;

    // handshake
    assign push      = front_valid_reg && !q_stat.full;
    assign busy      = front_valid_reg && q_stat.full;
    assign accept    = start && !busy;
    assign push_item = front_item_reg;
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // staging register occupancy
    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // classify and stage the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg.kind   <= item.op ? KIND_READ : KIND_WRITE;
            front_item_reg.addr   <= item.src_addr;
            front_item_reg.sample <= item.sample;
            front_item_reg.pix    <= item.pixel_index[OUT_INDEX_BITS-1:0];
        end
    end

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OUT_WIDTH:  cfg_next.out_width  = cfg_data[OUT_WIDTH_W-1:0];
                CFG_SCALE_STEP: cfg_next.scale_step = cfg_data[SCALE_W-1:0];
                CFG_SRC_WIDTH:  cfg_next.src_width  = cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: cfg_next.src_height = cfg_data[DIM_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_width  <= OUT_WIDTH_W'(1);
            cfg_reg.scale_step <= SCALE_W'(FRAC_ONE);
            cfg_reg.src_width  <= DIM_MIN;
            cfg_reg.src_height <= DIM_MIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bir_queue.sv @@
// bir_queue: short in-order queue between the front and the back
// depends on bir_pkg
`default_nettype none

module bir_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bir_pkg::q_item_t  push_item,
    output bir_pkg::q_stat_t       q_stat,
    input  wire logic              pop,
    output logic                   head_valid,
    output bir_pkg::q_item_t       head_item
);
    import bir_pkg::*;

    q_item_t             q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_pop;

    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head_valid   = !q_stat.empty;
    assign head_item    = q_mem_reg[rd_ptr_reg];
    assign do_pop       = pop && head_valid;

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 cnt_reg == $past(cnt_reg) + QCNT_W'($past(push)) - QCNT_W'($past(do_pop)))
        else $error("queue count out of step with transactions");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(cnt_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ rtl/bir_div.sv @@
// bir_div: pipelined restoring divider, one quotient bit per stage
// depends on bir_pkg; splits the pixel index into row and column
`default_nettype none

module bir_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [bir_pkg::OUT_WIDTH_W-1:0]     divisor,
    input  wire logic                                in_valid,
    input  wire bir_pkg::q_item_t                    in_item,
    output logic                                     out_valid,
    output bir_pkg::q_item_t                         out_item,
    output logic [bir_pkg::OUT_WIDTH_W-1:0]          out_rem,
    output logic [bir_pkg::OUT_INDEX_BITS-1:0]       out_quo
);
    import bir_pkg::*;

    localparam int N = OUT_INDEX_BITS;

    logic                    dv_valid_reg [1:N];
    q_item_t                 dv_item_reg  [1:N];
    logic [OUT_WIDTH_W-1:0]  dv_rem_reg   [1:N];
    logic [N-1:0]            dv_quo_reg   [1:N];
    logic [OUT_WIDTH_W-1:0]  w_eff;

    // a zero width acts as one
    assign w_eff = (divisor == '0) ? OUT_WIDTH_W'(1) : divisor;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic                   v_in;
            q_item_t                it_in;
            logic [OUT_WIDTH_W-1:0] r_in;
            logic [N-1:0]           q_in;
            logic [OUT_WIDTH_W:0]   trial;
            logic                   take;

            if (k == 0)
            begin : g_first
                assign v_in  = in_valid;
                assign it_in = in_item;
                assign r_in  = '0;
                assign q_in  = '0;
            end
            else
            begin : g_rest
                assign v_in  = dv_valid_reg[k];
                assign it_in = dv_item_reg[k];
                assign r_in  = dv_rem_reg[k];
                assign q_in  = dv_quo_reg[k];
            end

            // shift in one dividend bit and try the subtract
            assign trial = {r_in, it_in.pix[N-1-k]};
            assign take  = (trial >= {1'b0, w_eff});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    dv_valid_reg[k+1] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                dv_item_reg[k+1] <= it_in;
                dv_rem_reg[k+1]  <= take ? OUT_WIDTH_W'(trial - {1'b0, w_eff})
                                         : trial[OUT_WIDTH_W-1:0];
                dv_quo_reg[k+1]  <= {q_in[N-2:0], take};
            end
        end
    endgenerate

    assign out_valid = dv_valid_reg[N];
    assign out_item  = dv_item_reg[N];
    assign out_rem   = dv_rem_reg[N];
    assign out_quo   = dv_quo_reg[N];

endmodule

`default_nettype wire

@@ rtl/bir_back.sv @@
// bir_back: execution pipeline; divide, scale, clamp, address, fetch, blend
// depends on bir_pkg and bir_div; holds the two source image copies
`default_nettype none

module bir_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bir_pkg::cfg_t      cfg,
    input  wire logic               head_valid,
    input  wire bir_pkg::q_item_t   head_item,
    output logic                    pop,
    output logic                    done,
    output bir_pkg::res_item_t      result
);
    import bir_pkg::*;

    localparam int PX_W   = OUT_WIDTH_W + SCALE_W;
    localparam int PY_W   = OUT_INDEX_BITS + SCALE_W;
    localparam int WGT_W  = 2 * FRAC_W + 1;
    localparam int PROD_W = WGT_W + SAMPLE_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic                       dv_valid;
    q_item_t                    dv_item;
    logic [OUT_WIDTH_W-1:0]     dv_col;
    logic [OUT_INDEX_BITS-1:0]  dv_row;

    logic [DIM_W-1:0]  iw, ih;
    logic [CELL_W-1:0] lim_x, lim_y;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s4_valid_reg, s5_valid_reg, s6_valid_reg;
    q_item_t              s1_item_reg, s2_item_reg, s3_item_reg;
    q_item_t              s4_item_reg, s5_item_reg, s6_item_reg;
    logic [PX_W-1:0]      px_reg;
    logic [PY_W-1:0]      py_reg;
    logic [CELL_W-1:0]    cx_reg, cy_reg;
    logic [FRAC_W-1:0]    fx2_reg, fy2_reg, fx3_reg, fy3_reg;
    logic [ADDR_W-1:0]    a0_reg, a1_reg, a2_reg, a3_reg;
    logic [SAMPLE_W-1:0]  s00_reg, s01_reg, s10_reg, s11_reg;
    logic [WGT_W-1:0]     w00_reg, w01_reg, w10_reg, w11_reg;
    logic [PROD_W-1:0]    p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PROD_W:0]      sum0_reg, sum1_reg;
    logic                 done_reg;
    res_item_t            result_reg;

    logic [SAMPLE_W-1:0]  mem_a [DEPTH];
    logic [SAMPLE_W-1:0]  mem_b [DEPTH];

    logic [PX_W-FRAC_W-1:0] cx_full;
    logic [PY_W-FRAC_W-1:0] cy_full;
    logic [ADDR_W:0]        r0;
    logic [ADDR_W-1:0]      r1;
    logic [FRAC_W:0]        gx, gy;
    logic [PROD_W+1:0]      total;
    logic                   wr_en;

    // back side always takes the queue head
    assign pop = head_valid;

    bir_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .divisor  (cfg.out_width),
        .in_valid (head_valid),
        .in_item  (head_item),
        .out_valid(dv_valid),
        .out_item (dv_item),
        .out_rem  (dv_col),
        .out_quo  (dv_row)
    );

    // legal source size and cell limits
    assign iw    = clamp_dim(cfg.src_width, DIM_MAX_X);
    assign ih    = clamp_dim(cfg.src_height, DIM_MAX_Y);
    assign lim_x = CELL_W'(iw - DIM_MIN);
    assign lim_y = CELL_W'(ih - DIM_MIN);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= dv_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            done_reg     <= s6_valid_reg && (s6_item_reg.kind == KIND_READ);
        end
    end

    // scale both coordinates
    always_ff @(posedge clk)
    begin
        s1_item_reg <= dv_item;
        px_reg      <= PX_W'(dv_col * cfg.scale_step);
        py_reg      <= PY_W'(dv_row * cfg.scale_step);
    end

    // split into cell and fraction, clamp the cell
    assign cx_full = px_reg[PX_W-1:FRAC_W];
    assign cy_full = py_reg[PY_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        s2_item_reg <= s1_item_reg;
        cx_reg  <= (cx_full > (PX_W-FRAC_W)'(lim_x)) ? lim_x : cx_full[CELL_W-1:0];
        cy_reg  <= (cy_full > (PY_W-FRAC_W)'(lim_y)) ? lim_y : cy_full[CELL_W-1:0];
        fx2_reg <= px_reg[FRAC_W-1:0];
        fy2_reg <= py_reg[FRAC_W-1:0];
    end

    // neighbor addresses
    assign r0 = (ADDR_W+1)'(cy_reg * iw) + (ADDR_W+1)'(cx_reg);
    assign r1 = ADDR_W'(r0) + ADDR_W'(iw);

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s2_item_reg;
        a0_reg  <= ADDR_W'(r0);
        a1_reg  <= ADDR_W'(r0) + ADDR_W'(1);
        a2_reg  <= r1;
        a3_reg  <= r1 + ADDR_W'(1);
        fx3_reg <= fx2_reg;
        fy3_reg <= fy2_reg;
    end

    // source image copies, one per row of the two-by-two neighborhood
    assign wr_en = s3_valid_reg && (s3_item_reg.kind == KIND_WRITE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[s3_item_reg.addr] <= s3_item_reg.sample;
        end
        s00_reg <= mem_a[a0_reg];
        s01_reg <= mem_a[a1_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_b[s3_item_reg.addr] <= s3_item_reg.sample;
        end
        s10_reg <= mem_b[a2_reg];
        s11_reg <= mem_b[a3_reg];
    end

    // blend weights
    assign gx = FRAC_ONE - {1'b0, fx3_reg};
    assign gy = FRAC_ONE - {1'b0, fy3_reg};

    always_ff @(posedge clk)
    begin
        s4_item_reg <= s3_item_reg;
        w00_reg <= WGT_W'(gx * gy);
        w01_reg <= WGT_W'({1'b0, fx3_reg} * gy);
        w10_reg <= WGT_W'(gx * {1'b0, fy3_reg});
        w11_reg <= WGT_W'({1'b0, fx3_reg} * {1'b0, fy3_reg});
    end

    // weighted samples
    always_ff @(posedge clk)
    begin
        s5_item_reg <= s4_item_reg;
        p00_reg <= w00_reg * s00_reg;
        p01_reg <= w01_reg * s01_reg;
        p10_reg <= w10_reg * s10_reg;
        p11_reg <= w11_reg * s11_reg;
    end

    // pair sums
    always_ff @(posedge clk)
    begin
        s6_item_reg <= s5_item_reg;
        sum0_reg <= {1'b0, p00_reg} + {1'b0, p01_reg};
        sum1_reg <= {1'b0, p10_reg} + {1'b0, p11_reg};
    end

    // final sum with round half up
    assign total = {1'b0, sum0_reg} + {1'b0, sum1_reg}
                 + ((PROD_W+2)'(1) << (2 * FRAC_W - 1));

    always_ff @(posedge clk)
    begin
        result_reg.out_value <= total[2*FRAC_W +: SAMPLE_W];
        result_reg.out_index <= 24'(s6_item_reg.pix);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ rtl/bilinear_image_resampler.sv @@
// bilinear_image_resampler: top level of the bilinear image resampler
// depends on bir_pkg, bir_front, bir_queue, bir_back
//
// channel   direction  handshake               payload
// command   in         start / busy            item (in_item_t)
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
// result    out        done strobe             result (res_item_t)
//
// one transaction per cycle sustained while busy is low; a read's result
// passes the 24-stage divider and then seven blend stages
// write transactions store their sample in both image copies behind the
// divider and give no result
// rst_n clears all control state; source image contents are unknown
// until written
// results are not held off; busy rises only if the queue fills
`default_nettype none

module bilinear_image_resampler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire bir_pkg::in_item_t              item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [bir_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                done,
    output bir_pkg::res_item_t                  result
);
    import bir_pkg::*;

    cfg_t     cfg;
    q_stat_t  q_stat;
    logic     push;
    q_item_t  push_item;
    logic     pop;
    logic     head_valid;
    q_item_t  head_item;

    // intake and configuration
    bir_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_item(push_item)
    );

    // decoupling queue
    bir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item)
    );

    // execution pipeline
    bir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head_valid(head_valid),
        .head_item (head_item),
        .pop       (pop),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire
